// File: hdl/jsfe_pkg.sv
// ----------------------------------------------------------------------------
// jsfe_pkg
// shared types and constants for the json string field extractor
// ----------------------------------------------------------------------------
`default_nettype none

package jsfe_pkg;

    // parse phase, one-hot
    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_COLON  = 6'b000010,
        PH_QUOTE  = 6'b000100,
        PH_VALUE  = 6'b001000,
        PH_ESC    = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOKEY   = 2'd1;
    localparam status_t ST_INVALID = 2'd2;

    // register indexes on the config port
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_KEY_LENGTH = 2'd0;
    localparam reg_index_t REG_KEY_LOW    = 2'd1;
    localparam reg_index_t REG_KEY_HIGH   = 2'd2;

    // register reset values: key is "question" with both quotes
    localparam logic [4:0]  KEY_LENGTH_RST = 5'd10;
    localparam logic [63:0] KEY_LOW_RST    = 64'd8028075849736876322;
    localparam logic [63:0] KEY_HIGH_RST   = 64'd8814;

    // character codes
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

endpackage

`default_nettype wire

// File: hdl/jsfe_key_match.sv
// ----------------------------------------------------------------------------
// jsfe_key_match
// compares the byte window (newest first) with the configured key
// ----------------------------------------------------------------------------
`default_nettype none

module jsfe_key_match #(
    parameter int KEY_MAX = 16
) (
    input  wire logic [8*KEY_MAX-1:0]         window,
    input  wire logic [8*KEY_MAX-1:0]         key_vec,
    input  wire logic [$clog2(KEY_MAX+1)-1:0] seen,
    input  wire logic [$clog2(KEY_MAX+1)-1:0] key_len,
    output logic                              match
);

    localparam int LEN_W = $clog2(KEY_MAX + 1);
    localparam int IDX_W = $clog2(KEY_MAX);

    logic [7:0]       key_arr [KEY_MAX];
    logic [LEN_W-1:0] key_pos [KEY_MAX];
    logic [KEY_MAX-1:0] pos_ok;

    always_comb begin
        for (int k = 0; k < KEY_MAX; k++) begin
            key_arr[k] = key_vec[8*k +: 8];
        end
        // window byte p pairs with key byte len-1-p
        for (int p = 0; p < KEY_MAX; p++) begin
            key_pos[p] = key_len - LEN_W'(p) - LEN_W'(1);
            if (LEN_W'(p) < key_len) begin
                pos_ok[p] = (window[8*p +: 8] == key_arr[key_pos[p][IDX_W-1:0]]);
            end else begin
                pos_ok[p] = 1'b1;
            end
        end
        match = (&pos_ok) && (seen >= key_len);
    end

endmodule

`default_nettype wire

// File: hdl/json_string_field_extractor_core.sv
// ----------------------------------------------------------------------------
// json_string_field_extractor_core
// streams a json body a byte per beat, finds the configured key, then emits
// the decoded bytes of the string value that follows it
// ----------------------------------------------------------------------------
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  input    | s_valid s_ready s_in_byte s_body_end         | in
//  result   | m_valid m_ready m_value_byte m_has_byte      | out
//           | m_finished m_status                          |
//  config   | cfg_wr_en cfg_index cfg_wr_data              | in
//
//  one input beat per clock while s_ready is high; each beat is parsed in the cycle it is taken
//  and its result (if any) lands in the output register on the same edge
//  the output register is the only stage, so input stalls only while a
//  result waits there and m_ready is low
//  aresetn (synchronous, active low) clears the window, the parse phase,
//  the output valid flag and loads the default key "question" with quotes
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_field_extractor_core #(
    parameter int KEY_MAX = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_body_end,

    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_value_byte,
    output logic             m_has_byte,
    output logic             m_finished,
    output logic [1:0]       m_status,

    // config write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wr_data
);

    localparam int LEN_W = $clog2(KEY_MAX + 1);
    localparam int WIN_W = 8 * KEY_MAX;

    // config registers
    logic [4:0]  key_length_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;

    // parse state
    logic [WIN_W-1:0]        win_reg, win_next;
    logic [LEN_W-1:0]        seen_reg, seen_next;
    jsfe_pkg::phase_t        phase_reg, phase_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg;
    logic                    out_has_reg;
    logic                    out_fin_reg;
    jsfe_pkg::status_t       out_status_reg;

    // per-beat decode
    logic                    s_fire;
    logic [WIN_W-1:0]        win_shift;
    logic [LEN_W-1:0]        seen_inc;
    logic [LEN_W-1:0]        key_len_eff;
    logic [5:0]              key_len_wide;
    logic [255:0]            key_full;
    logic [WIN_W-1:0]        key_vec;
    logic                    key_hit;
    logic                    res_emit;
    logic                    res_fin;
    logic [7:0]              res_byte;
    jsfe_pkg::status_t       res_status;

    // --------------------------------------------------------------------
    // handshake: take a beat unless a result is stuck in the output reg
    // --------------------------------------------------------------------
    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // --------------------------------------------------------------------
    // config registers
    // --------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= jsfe_pkg::KEY_LENGTH_RST;
            key_low_reg    <= jsfe_pkg::KEY_LOW_RST;
            key_high_reg   <= jsfe_pkg::KEY_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                jsfe_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_wr_data[4:0];
                jsfe_pkg::REG_KEY_LOW:    key_low_reg    <= cfg_wr_data;
                jsfe_pkg::REG_KEY_HIGH:   key_high_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // effective key length: zero means one, clamp at window depth
    always_comb begin
        key_len_wide = {1'b0, key_length_reg};
        if (key_len_wide == 6'd0) begin
            key_len_eff = LEN_W'(1);
        end else if (key_len_wide > 6'(KEY_MAX)) begin
            key_len_eff = LEN_W'(KEY_MAX);
        end else begin
            key_len_eff = LEN_W'(key_len_wide);
        end
    end

    // key bytes past the two registers read as zero
    assign key_full = {128'd0, key_high_reg, key_low_reg};
    assign key_vec  = key_full[WIN_W-1:0];

    // window with the new byte shifted in at the newest end
    assign win_shift = {win_reg[WIN_W-9:0], s_in_byte};
    assign seen_inc  = (seen_reg < LEN_W'(KEY_MAX)) ? seen_reg + LEN_W'(1) : seen_reg;

    jsfe_key_match #(
        .KEY_MAX (KEY_MAX)
    ) u_key_match (
        .window  (win_shift),
        .key_vec (key_vec),
        .seen    (seen_inc),
        .key_len (key_len_eff),
        .match   (key_hit)
    );

    // --------------------------------------------------------------------
    // parse step for the incoming beat
    // --------------------------------------------------------------------
    always_comb begin
        win_next   = win_reg;
        seen_next  = seen_reg;
        phase_next = phase_reg;
        res_emit   = 1'b0;
        res_fin    = 1'b0;
        res_byte   = 8'd0;
        res_status = jsfe_pkg::ST_OK;

        case (phase_reg)
            jsfe_pkg::PH_SEARCH: begin
                win_next  = win_shift;
                seen_next = seen_inc;
                if (key_hit) begin
                    phase_next = jsfe_pkg::PH_COLON;
                end
                if (s_body_end) begin
                    res_fin    = 1'b1;
                    res_status = key_hit ? jsfe_pkg::ST_INVALID : jsfe_pkg::ST_NOKEY;
                end
            end
            jsfe_pkg::PH_COLON: begin
                if (s_in_byte == jsfe_pkg::CHAR_COLON) begin
                    phase_next = jsfe_pkg::PH_QUOTE;
                end
                if (s_body_end) begin
                    res_fin    = 1'b1;
                    res_status = jsfe_pkg::ST_INVALID;
                end
            end
            jsfe_pkg::PH_QUOTE: begin
                if (s_in_byte == jsfe_pkg::CHAR_QUOTE) begin
                    phase_next = jsfe_pkg::PH_VALUE;
                end
                // opening quote on the last byte is an empty value
                if (s_body_end) begin
                    res_fin    = 1'b1;
                    res_status = (s_in_byte == jsfe_pkg::CHAR_QUOTE) ?
                                 jsfe_pkg::ST_OK : jsfe_pkg::ST_INVALID;
                end
            end
            jsfe_pkg::PH_VALUE: begin
                if (s_in_byte == jsfe_pkg::CHAR_BACKSLASH) begin
                    phase_next = jsfe_pkg::PH_ESC;
                    res_fin    = s_body_end;
                end else if (s_in_byte == jsfe_pkg::CHAR_QUOTE) begin
                    // closing quote, rest of body is ignored
                    res_fin    = 1'b1;
                    phase_next = jsfe_pkg::PH_DONE;
                end else begin
                    res_emit = 1'b1;
                    res_byte = s_in_byte;
                    res_fin  = s_body_end;
                end
            end
            jsfe_pkg::PH_ESC: begin
                res_emit   = 1'b1;
                res_byte   = (s_in_byte == jsfe_pkg::CHAR_LOWER_N) ?
                             jsfe_pkg::CHAR_NEWLINE : s_in_byte;
                phase_next = jsfe_pkg::PH_VALUE;
                res_fin    = s_body_end;
            end
            default: begin
                // done: swallow bytes until the body ends
            end
        endcase

        // end of body returns the parser to its start
        if (s_body_end) begin
            win_next   = '0;
            seen_next  = '0;
            phase_next = jsfe_pkg::PH_SEARCH;
        end
    end

    // --------------------------------------------------------------------
    // state registers
    // --------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            seen_reg  <= '0;
            phase_reg <= jsfe_pkg::PH_SEARCH;
        end else if (s_fire) begin
            win_reg   <= win_next;
            seen_reg  <= seen_next;
            phase_reg <= phase_next;
        end
    end

    // --------------------------------------------------------------------
    // output register
    // --------------------------------------------------------------------
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_fire) begin
            out_valid_next = res_emit || res_fin;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, loaded only when a beat yields a result
    always_ff @(posedge aclk) begin
        if (s_fire && (res_emit || res_fin)) begin
            out_byte_reg   <= res_byte;
            out_has_reg    <= res_emit;
            out_fin_reg    <= res_fin;
            out_status_reg <= res_fin ? res_status : jsfe_pkg::ST_OK;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_value_byte = out_byte_reg;
    assign m_has_byte   = out_has_reg;
    assign m_finished   = out_fin_reg;
    assign m_status     = out_status_reg;

endmodule

`default_nettype wire
